/* rtl/bkc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bkc_pkg: shared types and constants of the barcode key counter
// Field widths, result status codes, register indexes and the base coder.
// ---------------------------------------------------------------------------
package bkc_pkg;

    // default sizing
    localparam int BKC_CAPACITY   = 1024;
    localparam int BKC_WELL_SHIFT = 60;

    // field widths
    localparam int CHAR_W    = 8;
    localparam int WELL_W    = 4;
    localparam int ACC_W     = 60;
    localparam int KEY_W     = 64;
    localparam int COUNT_W   = 32;
    localparam int READS_W   = 40;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int ENTRY_W   = KEY_W + COUNT_W;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_WELL  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

    // nucleotide characters
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    // result of one table lookup, scan unit to top level
    typedef struct packed {
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_scan_res;

    // 2-bit base code, unknown characters code as A
    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [1:0] code;
        begin
            case (ch)
                CHAR_A:  code = 2'd0;
                CHAR_C:  code = 2'd1;
                CHAR_G:  code = 2'd2;
                CHAR_T:  code = 2'd3;
                default: code = 2'd0;
            endcase
            return code;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/bkc_scan.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bkc_scan: key table and linear lookup sequencer
// Holds keys and counts in one synchronous memory, walks the used entries
// one per cycle, then increments a hit, appends a new entry or reports a full table.
// ---------------------------------------------------------------------------
module bkc_scan #(
    parameter int CAPACITY = bkc_pkg::BKC_CAPACITY
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [bkc_pkg::KEY_W-1:0] i_key,
    output logic                           o_busy,
    output bkc_pkg::t_scan_res             o_res
);
    import bkc_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // entry memory, key in the upper bits, count in the lower
    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] r_rd_data;

    logic               r_state, n_state;
    logic [KEY_W-1:0]   r_key;
    logic [CW-1:0]      r_iss, n_iss;
    logic               r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]      r_cmp_addr, n_cmp_addr;
    logic [CW-1:0]      r_used, n_used;

    logic               rd_en;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               match;
    logic               all_seen;
    logic [COUNT_W-1:0] hit_count;
    logic               in_scan;

    assign in_scan  = (r_state == ST_SCAN);
    assign match    = r_cmp_vld && (r_rd_data[ENTRY_W-1:COUNT_W] == r_key);
    assign all_seen = (r_iss == r_used);
    assign rd_en    = in_scan && !match && !all_seen;
    assign o_busy   = in_scan;

    // saturating increment of the entry that matched
    assign hit_count = (r_rd_data[COUNT_W-1:0] == COUNT_MAX) ? COUNT_MAX
                     : r_rd_data[COUNT_W-1:0] + COUNT_W'(1);

    // sequencer: issue reads, compare in the following cycle, finish on hit or end
    always_comb begin
        n_state    = r_state;
        n_iss      = r_iss;
        n_cmp_vld  = 1'b0;
        n_cmp_addr = r_cmp_addr;
        n_used     = r_used;
        wr_en      = 1'b0;
        wr_addr    = r_cmp_addr;
        wr_data    = {r_key, hit_count};
        o_res      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_iss   = '0;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    wr_en        = 1'b1;
                    o_res.done   = 1'b1;
                    o_res.status = STAT_FOUND;
                    o_res.count  = hit_count;
                    n_state      = ST_IDLE;
                end else if (all_seen) begin
                    o_res.done = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_used < CW'(CAPACITY)) begin
                        wr_en        = 1'b1;
                        wr_addr      = r_used[AW-1:0];
                        wr_data      = {r_key, COUNT_W'(1)};
                        n_used       = r_used + CW'(1);
                        o_res.status = STAT_NEW;
                        o_res.count  = COUNT_W'(1);
                    end else begin
                        o_res.status = STAT_FULL;
                    end
                end else begin
                    n_iss      = r_iss + CW'(1);
                    n_cmp_vld  = 1'b1;
                    n_cmp_addr = r_iss[AW-1:0];
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_iss     <= '0;
            r_cmp_vld <= 1'b0;
            r_used    <= '0;
        end else begin
            r_state   <= n_state;
            r_iss     <= n_iss;
            r_cmp_vld <= n_cmp_vld;
            r_used    <= n_used;
        end
    end

    // lookup key and compare address
    always_ff @(posedge i_clk) begin
        r_cmp_addr <= n_cmp_addr;
        if (i_start && !in_scan) begin
            r_key <= i_key;
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_iss[AW-1:0]];
        end
    end

    // fill count stays within the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // a new lookup only starts while idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !in_scan)
        else $error("lookup started while scanning");

    // each finished lookup returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done |=> !in_scan)
        else $error("scan did not end after a result");

    // appending an entry grows the fill count by one
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.done && o_res.status == STAT_NEW) |=> r_used == $past(r_used) + CW'(1))
        else $error("fill count not advanced on append");

    // a compare never refers past the used entries
    a_cmp_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> ({1'b0, r_cmp_addr} < {1'b0, r_used}))
        else $error("compare beyond used entries");

endmodule
`default_nettype wire

/* rtl/barcode_key_counter_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// barcode_key_counter_top: barcode key frequency table
// Accumulates read bases into a key and counts each key per well.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one base word per read base; i_last_base closes a read
//   and carries the well number and its valid flag. Only a closing word
//   gives a result word on the output channel.
//   Config channel: index 0 sets the inclusive low key bound, index 1 the
//   exclusive high bound (zero turns range filtering off). Write only while
//   the block is idle; o_cfg_ready is always high.
//   Timing: a base that does not close a read only shifts the accumulator. A
//   closing word with no well or a key out of range gives its result on the
//   next cycle. Otherwise the table is searched linearly, one stored entry per
//   cycle through the memory read port, and no new input word is taken until
//   that lookup ends.
//   Reset clears the accumulator, read total and fill count at once; the
//   memory needs no clearing pass, only filled entries are read.
//   A result waits in the output register while the receiver stalls; the
//   input then takes no new word until that result can leave.
// ---------------------------------------------------------------------------
module barcode_key_counter_top #(
    parameter int CAPACITY   = bkc_pkg::BKC_CAPACITY,
    parameter int WELL_SHIFT = bkc_pkg::BKC_WELL_SHIFT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [bkc_pkg::CHAR_W-1:0]    i_base_char,
    input  wire logic                          i_last_base,
    input  wire logic [bkc_pkg::WELL_W-1:0]    i_well_index,
    input  wire logic                          i_well_valid,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bkc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bkc_pkg::KEY_W-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bkc_pkg::STATUS_W-1:0]       o_status,
    output logic [bkc_pkg::KEY_W-1:0]          o_key,
    output logic [bkc_pkg::COUNT_W-1:0]        o_key_count,
    output logic [bkc_pkg::READS_W-1:0]        o_reads_total
);
    import bkc_pkg::*;

    localparam logic [KEY_W-1:0]   LOW_MASK  = (KEY_W'(1) << WELL_SHIFT) - KEY_W'(1);
    localparam logic [READS_W-1:0] READS_MAX = '1;

    logic [KEY_W-1:0]    r_range_low;
    logic [KEY_W-1:0]    r_range_high;
    logic [ACC_W-1:0]    r_acc;
    logic [READS_W-1:0]  r_reads;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [KEY_W-1:0]    r_key;
    logic [COUNT_W-1:0]  r_count;
    logic [READS_W-1:0]  r_out_reads;

    logic                in_acc;
    logic [ACC_W-1:0]    acc_next;
    logic [KEY_W-1:0]    key_formed;
    logic [READS_W-1:0]  reads_next;
    logic                out_range;
    logic                scan_start;
    logic                scan_busy;
    t_scan_res           scan_res;

    // handshakes
    assign o_in_ready  = !scan_busy && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    // key formation and range filter
    assign acc_next   = {r_acc[ACC_W-3:0], base_code(i_base_char)};
    assign key_formed = ({{(KEY_W-ACC_W){1'b0}}, acc_next} & LOW_MASK)
                      | ({{(KEY_W-WELL_W){1'b0}}, i_well_index} << WELL_SHIFT);
    assign out_range  = (r_range_high != '0)
                      && !((r_range_low <= key_formed) && (key_formed < r_range_high));
    assign reads_next = (r_reads == READS_MAX) ? READS_MAX : r_reads + READS_W'(1);
    assign scan_start = in_acc && i_last_base && i_well_valid && !out_range;

    bkc_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_key   (key_formed),
        .o_busy  (scan_busy),
        .o_res   (scan_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                REG_RANGE_HIGH: r_range_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // base accumulator and read total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_reads <= '0;
        end else if (in_acc) begin
            if (i_last_base) begin
                r_acc <= '0;
                if (i_well_valid) begin
                    r_reads <= reads_next;
                end
            end else begin
                r_acc <= acc_next;
            end
        end
    end

    // output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((in_acc && i_last_base && !scan_start) || scan_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (scan_res.done) begin
            r_status    <= scan_res.status;
            r_count     <= scan_res.count;
            r_out_reads <= r_reads;
        end else if (in_acc && i_last_base) begin
            if (!i_well_valid) begin
                r_status    <= STAT_NO_WELL;
                r_key       <= '0;
                r_count     <= '0;
                r_out_reads <= r_reads;
            end else begin
                r_status    <= STAT_RANGE;
                r_key       <= key_formed;
                r_count     <= '0;
                r_out_reads <= reads_next;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_key         = r_key;
    assign o_key_count   = r_count;
    assign o_reads_total = r_out_reads;

    // no new input while a lookup is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_busy |-> !in_acc)
        else $error("input taken during lookup");

    // a lookup result never lands on a pending output word
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.done |-> !r_out_valid)
        else $error("lookup result overwrote pending output");

    // read total only moves on a closing word with a well
    a_reads_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && i_last_base && i_well_valid) |=> $stable(r_reads))
        else $error("read total changed without a counted read");

endmodule
`default_nettype wire
